// ===== rtl/scc_pkg.sv =====
package scc_pkg;

    // Field and format widths.
    localparam int FIELD_BITS  = 16;
    localparam int ANGLE_BITS  = 16;
    localparam int RADIUS_BITS = 16;
    localparam int RIN_BITS    = (RADIUS_BITS < FIELD_BITS) ? RADIUS_BITS : FIELD_BITS;
    localparam int PHASE_BITS  = 32;
    localparam int STEPS       = 16;
    localparam int CW          = 34;
    localparam int MUL1_BITS   = 2 * FIELD_BITS;
    localparam int PROD_BITS   = 3 * FIELD_BITS;
    localparam int ITEM_BITS   = 3 * FIELD_BITS;

    // Lane numbers inside the rotator.
    localparam int LANE_AZ = 0;
    localparam int LANE_EL = 1;

    typedef logic signed [FIELD_BITS-1:0] samp_t;
    typedef logic signed [CW-1:0]         cw_t;
    typedef logic signed [MUL1_BITS-1:0]  mul1_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;

    // CORDIC start value (gain-compensated unit vector) in Q2.30.
    localparam cw_t CORDIC_GAIN = 34'sd652032874;

    // Rounding offsets for the Q15 and Q30 products.
    localparam mul1_t ROUND_Q15 = 32'sd16384;
    localparam prod_t ROUND_Q30 = 48'sd536870912;

    // Output saturation bounds, signed radius range.
    localparam prod_t OUT_HI = prod_t'((longint'(1) <<< (RADIUS_BITS - 1)) - 1);
    localparam prod_t OUT_LO = prod_t'(-(longint'(1) <<< (RADIUS_BITS - 1)));

    // Arctangent of 2^-i in units of 2^32 per turn.
    localparam logic [PHASE_BITS-1:0] ATAN_TURN32 [STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    // One input item, radius in the lowest bits.
    typedef struct packed {
        samp_t elevation_angle;
        samp_t azimuth;
        samp_t radius_in;
    } item_t;

    // One result item, x in the lowest bits.
    typedef struct packed {
        samp_t z_out;
        samp_t y_out;
        samp_t x_out;
    } res_t;

    // Rounded sine and cosine values with the radius that goes with them.
    typedef struct packed {
        samp_t radius;
        samp_t cos_az;
        samp_t sin_az;
        samp_t cos_el;
        samp_t sin_el;
    } trig_t;

    // Saturate a Q2.30 rotator value after rounding to Q1.15.
    function automatic samp_t sat_q15(cw_t v);
        cw_t t;
        t = (v + cw_t'(16384)) >>> 15;
        if (t > cw_t'(32767)) begin
            return samp_t'(16'sh7FFF);
        end else if (t < cw_t'(-32768)) begin
            return samp_t'(16'sh8000);
        end
        return samp_t'(t[FIELD_BITS-1:0]);
    endfunction

    // Saturate a coordinate to the radius range and keep the field bits.
    function automatic samp_t sat_out(prod_t v);
        prod_t t;
        if (v > OUT_HI) begin
            t = OUT_HI;
        end else if (v < OUT_LO) begin
            t = OUT_LO;
        end else begin
            t = v;
        end
        return samp_t'(t[FIELD_BITS-1:0]);
    endfunction

endpackage

// ===== rtl/scc_cordic.sv =====
module scc_cordic
    import scc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output trig_t out_trig
);

    // Rotator state per stage and lane; stage 0 holds the pre-rotated start.
    cw_t          x_reg   [0:STEPS][0:1];
    cw_t          y_reg   [0:STEPS][0:1];
    cw_t          z_reg   [0:STEPS][0:1];
    samp_t        rad_reg [0:STEPS];
    logic [STEPS:0] vld_reg;

    cw_t          x0_next [0:1];
    cw_t          z0_next [0:1];
    samp_t        rad0_next;

    trig_t        trig_reg;
    logic         trig_vld_reg;
    trig_t        trig_next;

    // Scale each angle to a 32-bit turn and fold it into +-90 degrees.
    always_comb begin
        logic [PHASE_BITS-1:0] ext;
        logic [PHASE_BITS-1:0] phase;
        samp_t                 ang;
        for (int l = 0; l < 2; l++) begin
            ang   = (l == LANE_EL) ? in_item.elevation_angle : in_item.azimuth;
            ext   = PHASE_BITS'(ang);
            phase = ext << (PHASE_BITS - ANGLE_BITS);
            if (phase[PHASE_BITS-1:PHASE_BITS-2] == 2'b01 ||
                phase[PHASE_BITS-1:PHASE_BITS-2] == 2'b10) begin
                phase      = phase ^ {1'b1, {(PHASE_BITS-1){1'b0}}};
                x0_next[l] = -CORDIC_GAIN;
            end else begin
                x0_next[l] = CORDIC_GAIN;
            end
            z0_next[l] = CW'(signed'(phase));
        end
        rad0_next = FIELD_BITS'(signed'(in_item.radius_in[RIN_BITS-1:0]));
    end

    // Start stage.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 2; l++) begin
                x_reg[0][l] <= x0_next[l];
                y_reg[0][l] <= '0;
                z_reg[0][l] <= z0_next[l];
            end
            rad_reg[0] <= rad0_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < STEPS; i++) begin : g_step
        cw_t x_next [0:1];
        cw_t y_next [0:1];
        cw_t z_next [0:1];
        cw_t angle_step;

        assign angle_step = signed'(CW'(ATAN_TURN32[i]));

        always_comb begin
            cw_t dx;
            cw_t dy;
            for (int l = 0; l < 2; l++) begin
                dx = y_reg[i][l] >>> i;
                dy = x_reg[i][l] >>> i;
                if (!z_reg[i][l][CW-1]) begin
                    x_next[l] = x_reg[i][l] - dx;
                    y_next[l] = y_reg[i][l] + dy;
                    z_next[l] = z_reg[i][l] - angle_step;
                end else begin
                    x_next[l] = x_reg[i][l] + dx;
                    y_next[l] = y_reg[i][l] - dy;
                    z_next[l] = z_reg[i][l] + angle_step;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int l = 0; l < 2; l++) begin
                    x_reg[i+1][l] <= x_next[l];
                    y_reg[i+1][l] <= y_next[l];
                    z_reg[i+1][l] <= z_next[l];
                end
                rad_reg[i+1] <= rad_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end
    end

    // Round the rotated vectors to Q1.15.
    always_comb begin
        trig_next.radius = rad_reg[STEPS];
        trig_next.cos_az = sat_q15(x_reg[STEPS][LANE_AZ]);
        trig_next.sin_az = sat_q15(y_reg[STEPS][LANE_AZ]);
        trig_next.cos_el = sat_q15(x_reg[STEPS][LANE_EL]);
        trig_next.sin_el = sat_q15(y_reg[STEPS][LANE_EL]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            trig_reg <= trig_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_vld_reg <= 1'b0;
        end else if (en) begin
            trig_vld_reg <= vld_reg[STEPS];
        end
    end

    assign out_valid = trig_vld_reg;
    assign out_trig  = trig_reg;

    // The residual angle must have converged to within +-65536 units of 2^32 per turn.
    a_residual_small: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[STEPS] |->
            (z_reg[STEPS][LANE_AZ] < cw_t'(65536)) &&
            (z_reg[STEPS][LANE_AZ] > cw_t'(-65536)) &&
            (z_reg[STEPS][LANE_EL] < cw_t'(65536)) &&
            (z_reg[STEPS][LANE_EL] > cw_t'(-65536)))
        else $error("CORDIC residual angle did not converge");

endmodule

// ===== rtl/scc_product.sv =====
module scc_product
    import scc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  trig_t in_trig,
    output logic  out_valid,
    output res_t  out_res
);

    // First multiply stage: radius times the elevation terms.
    mul1_t pc_reg, pc_next;
    mul1_t ps_reg, ps_next;
    samp_t caz_reg, saz_reg;
    logic  vld1_reg;

    // Second multiply stage: times the azimuth terms, y rounded.
    prod_t px_reg, px_next;
    prod_t pz_reg, pz_next;
    samp_t y_reg, y_next;
    logic  vld2_reg;

    // Output register.
    res_t  res_reg, res_next;
    logic  res_vld_reg;

    assign pc_next = mul1_t'(in_trig.radius) * mul1_t'(in_trig.cos_el);
    assign ps_next = mul1_t'(in_trig.radius) * mul1_t'(in_trig.sin_el);

    always_ff @(posedge aclk) begin
        if (en) begin
            pc_reg  <= pc_next;
            ps_reg  <= ps_next;
            caz_reg <= in_trig.cos_az;
            saz_reg <= in_trig.sin_az;
        end
    end

    assign px_next = prod_t'(pc_reg) * prod_t'(caz_reg);
    assign pz_next = prod_t'(pc_reg) * prod_t'(saz_reg);

    // Round r*sin(el) to radius units and saturate.
    always_comb begin
        mul1_t yr;
        yr     = (ps_reg + ROUND_Q15) >>> 15;
        y_next = sat_out(PROD_BITS'(yr));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= px_next;
            pz_reg <= pz_next;
            y_reg  <= y_next;
        end
    end

    // Round the Q30 products to radius units and saturate.
    always_comb begin
        res_next.x_out = sat_out((px_reg + ROUND_Q30) >>> 30);
        res_next.y_out = y_reg;
        res_next.z_out = sat_out((pz_reg + ROUND_Q30) >>> 30);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    // Valid bits follow the data through the three stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg    <= 1'b0;
            vld2_reg    <= 1'b0;
            res_vld_reg <= 1'b0;
        end else if (en) begin
            vld1_reg    <= in_valid;
            vld2_reg    <= vld1_reg;
            res_vld_reg <= vld2_reg;
        end
    end

    assign out_valid = res_vld_reg;
    assign out_res   = res_reg;

endmodule

// ===== rtl/spherical_to_cartesian.sv =====
// Channel   Direction  tdata fields, lowest bit up                      tlast  tuser
// s_        in         radius_in[15:0] azimuth[31:16] elevation[47:32]  none   none
// m_        out        x_out[15:0] y_out[31:16] z_out[47:32]            none   none
//
// One item is accepted per cycle while m_ does not stall; each item passes
// through one start stage, 16 CORDIC micro-rotation stages, one rounding stage
// and three multiply and saturate stages.
// Reset (aresetn low, synchronous) clears all valid bits and the input skid.
// A stall on m_ freezes the whole pipeline; the input skid register still
// takes one more item, so s_tready drops only once the skid is full.
module spherical_to_cartesian
    import scc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [ITEM_BITS-1:0] s_tdata,   // radius_in, azimuth, elevation_angle
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [ITEM_BITS-1:0] m_tdata    // x_out, y_out, z_out
);

    logic  en;
    logic  skid_valid_reg, skid_valid_next;
    item_t skid_item_reg;
    logic  pipe_valid;
    item_t pipe_item;

    logic  trig_valid;
    trig_t trig;
    logic  res_valid;
    res_t  res;

    // The pipeline advances whenever the output register is free or drained.
    assign en       = !res_valid || m_tready;
    assign s_tready = !skid_valid_reg;

    // Input skid: holds one item that arrives while the pipeline is stalled.
    always_comb begin
        if (en) begin
            skid_valid_next = 1'b0;
        end else begin
            skid_valid_next = skid_valid_reg || s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready && !en) begin
            skid_item_reg <= item_t'(s_tdata);
        end
    end

    assign pipe_valid = skid_valid_reg || s_tvalid;
    assign pipe_item  = skid_valid_reg ? skid_item_reg : item_t'(s_tdata);

    scc_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (pipe_valid),
        .in_item   (pipe_item),
        .out_valid (trig_valid),
        .out_trig  (trig)
    );

    scc_product u_product (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (trig_valid),
        .in_trig   (trig),
        .out_valid (res_valid),
        .out_res   (res)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = res;

    // An item accepted during a stall must land in the skid.
    a_skid_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !en) |=> skid_valid_reg)
        else $error("item accepted during stall was not captured");

    // A held item leaves the skid as soon as the pipeline moves.
    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && en) |=> !skid_valid_reg)
        else $error("skid item not forwarded when the pipeline advanced");

    // The skid only fills while the pipeline is stalled.
    a_skid_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(!en))
        else $error("skid filled while the pipeline was advancing");

endmodule

// ===== tb/sv/spherical_to_cartesian_test.sv =====
module spherical_to_cartesian_test;
    import scc_pkg::*;

    // Widths of the angle and radius formats that the checks assume.
    localparam int ANGLE_W     = 16;
    localparam int RADIUS_W    = 16;
    localparam int ROT_STEPS   = 16;
    localparam longint ROT_GAIN = 64'sd652032874;
    localparam int RANDOM_ITEMS = 900;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;

    // Arctangent of 2^-i with 2^32 per turn.
    localparam longint ATAN_STEP [ROT_STEPS] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    // One row of the directed table; the coordinates count only when known is set.
    typedef struct packed {
        logic [15:0] radius;
        logic [15:0] azim;
        logic [15:0] elev;
        logic        known;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
    } dir_row_t;

    localparam int DIR_ROWS = 21;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, 16'h0000},
        '{16'h0000, 16'h8000, 16'h4000, 1'b1, 16'h0000, 16'h0000, 16'h0000},
        '{16'h0000, 16'h7FFF, 16'h8000, 1'b1, 16'h0000, 16'h0000, 16'h0000},
        '{16'h7FFF, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{16'h8000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{16'h7FFF, 16'h4000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{16'h7FFF, 16'hC000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{16'h7FFF, 16'h8000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{16'h7FFF, 16'h0000, 16'h4000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{16'h8000, 16'h0000, 16'h4000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{16'h8000, 16'h0000, 16'hC000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{16'h8000, 16'h8000, 16'h8000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{16'h0001, 16'h2000, 16'h2000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{16'hFFFF, 16'hE000, 16'h6000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{16'h7FFF, 16'h2000, 16'hE000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{16'h8000, 16'hA000, 16'h2000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{16'h3039, 16'h0001, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{16'h8000, 16'h4000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{16'h7FFF, 16'h5555, 16'hAAAA, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{16'h8001, 16'hAAAA, 16'h5555, 1'b0, 16'h0000, 16'h0000, 16'h0000}
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [ITEM_BITS-1:0] s_tdata  = '0;   // radius_in, azimuth, elevation_angle
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [ITEM_BITS-1:0] m_tdata;         // x_out, y_out, z_out

    // Stimulus list, with typed-in coordinates for the rows that have them.
    item_t stim_items [$];
    bit    stim_known [$];
    res_t  stim_coords [$];

    // Coordinates still owed by the block, oldest first.
    res_t  coord_q [$];

    int          send_idx    = 0;
    int          n_results   = 0;
    int          n_errors    = 0;
    int          idle_cycles = 0;
    int          burst_left  = 1;
    int          gap_left    = 0;
    logic [15:0] stall_pat   = 16'hFFFF;
    int          pat_cnt     = 0;

    spherical_to_cartesian i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    function automatic longint clamp_range(longint v, longint lo, longint hi);
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // Rotate the gain-compensated unit vector to the angle, giving Q1.15 cosine and sine.
    function automatic void rotate_sincos(input logic [15:0] ang,
                                          output longint cos_v, output longint sin_v);
        logic [31:0] p;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        p = 32'(longint'($signed(ang)) << (32 - ANGLE_W));
        x = ROT_GAIN;
        y = 0;
        // Angles in the left half plane start from the mirrored vector.
        if (p[31:30] == 2'b01 || p[31:30] == 2'b10) begin
            p = p + 32'h8000_0000;
            x = -ROT_GAIN;
        end
        z = longint'($signed(p));
        for (int i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEP[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEP[i];
            end
        end
        cos_v = clamp_range((x + 16384) >>> 15, -32768, 32767);
        sin_v = clamp_range((y + 16384) >>> 15, -32768, 32767);
    endfunction

    // Cartesian point for one item, rounded and saturated to the radius range.
    function automatic res_t predict_point(item_t it);
        longint r;
        longint caz;
        longint saz;
        longint cel;
        longint sel;
        longint hi;
        longint lo;
        res_t   p;
        hi = (longint'(1) <<< (RADIUS_W - 1)) - 1;
        lo = -hi - 1;
        r  = longint'($signed(it.radius_in));
        rotate_sincos(it.azimuth, caz, saz);
        rotate_sincos(it.elevation_angle, cel, sel);
        p.x_out = 16'(clamp_range((r * cel * caz + (longint'(1) <<< 29)) >>> 30, lo, hi));
        p.y_out = 16'(clamp_range((r * sel + 16384) >>> 15, lo, hi));
        p.z_out = 16'(clamp_range((r * cel * saz + (longint'(1) <<< 29)) >>> 30, lo, hi));
        return p;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic logic [15:0] pick_angle();
        // Mostly anywhere on the circle, sometimes right at a quadrant boundary.
        if ($urandom_range(0, 3) == 0) begin
            return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 6) - 3);
        end
        return 16'($urandom);
    endfunction

    // Sender and checker: push the prediction on each accepted item, check each result.
    always @(posedge aclk) begin
        int    nxt;
        res_t  got;
        res_t  want;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            nxt = send_idx;
            if (s_tvalid && s_tready) begin
                if (stim_known[send_idx]) begin
                    coord_q.push_back(stim_coords[send_idx]);
                end else begin
                    coord_q.push_back(predict_point(stim_items[send_idx]));
                end
                nxt = send_idx + 1;
            end

            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata);
                if (coord_q.size() == 0) begin
                    report_error($sformatf("result %0d arrived with nothing expected", n_results));
                end else begin
                    want = coord_q.pop_front();
                    if (got.x_out !== want.x_out) begin
                        report_error($sformatf("result %0d x_out %h, expected %h",
                                               n_results, got.x_out, want.x_out));
                    end
                    if (got.y_out !== want.y_out) begin
                        report_error($sformatf("result %0d y_out %h, expected %h",
                                               n_results, got.y_out, want.y_out));
                    end
                    if (got.z_out !== want.z_out) begin
                        report_error($sformatf("result %0d z_out %h, expected %h",
                                               n_results, got.z_out, want.z_out));
                    end
                end
                n_results <= n_results + 1;
            end

            // Offer items in bursts; an item not yet taken is held as it is.
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (nxt < stim_items.size() && gap_left == 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= stim_items[nxt];
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 25)
                                                             : $urandom_range(0, 4);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end
            end
            send_idx <= nxt;
        end
    end

    // Receiver: walk a rotating ready pattern that changes character whenever pat_cnt wraps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            stall_pat <= 16'hFFFF;
            pat_cnt   <= 0;
        end else begin
            if (pat_cnt == 47) begin
                pat_cnt <= 0;
                case ($urandom_range(0, 3))
                    0: begin
                        stall_pat <= 16'hFFFF;
                    end
                    1: begin
                        stall_pat <= 16'($urandom);
                    end
                    2: begin
                        stall_pat <= 16'($urandom & $urandom);
                    end
                    default: begin
                        stall_pat <= 16'($urandom | $urandom);
                    end
                endcase
            end else begin
                pat_cnt   <= pat_cnt + 1;
                stall_pat <= {stall_pat[14:0], stall_pat[15]};
            end
            m_tready <= stall_pat[15];
        end
    end

    // Watchdog: end the run when no item moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        item_t it;
        int    mode;
        // Directed rows first.
        for (int i = 0; i < DIR_ROWS; i++) begin
            it.radius_in       = DIR_TABLE[i].radius;
            it.azimuth         = DIR_TABLE[i].azim;
            it.elevation_angle = DIR_TABLE[i].elev;
            stim_items.push_back(it);
            stim_known.push_back(DIR_TABLE[i].known);
            stim_coords.push_back({DIR_TABLE[i].z, DIR_TABLE[i].y, DIR_TABLE[i].x});
        end
        // Random items: full-range fields, extreme radii, tiny radii, angles sometimes near quadrant edges.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            mode = $urandom_range(0, 19);
            if (mode < 14) begin
                it.radius_in = 16'($urandom);
            end else if (mode < 17) begin
                case ($urandom_range(0, 2))
                    0: begin
                        it.radius_in = 16'h7FFF;
                    end
                    1: begin
                        it.radius_in = 16'h8000;
                    end
                    default: begin
                        it.radius_in = 16'h8001;
                    end
                endcase
            end else begin
                it.radius_in = 16'($urandom_range(0, 8) - 4);
            end
            it.azimuth         = pick_angle();
            it.elevation_angle = pick_angle();
            stim_items.push_back(it);
            stim_known.push_back(1'b0);
            stim_coords.push_back('0);
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (send_idx < stim_items.size() || coord_q.size() != 0) begin
            @(posedge aclk);
        end
        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (n_errors == 0 && coord_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/scc_pkg.sv
rtl/scc_cordic.sv
rtl/scc_product.sv
rtl/spherical_to_cartesian.sv
tb/sv/spherical_to_cartesian_test.sv
